[rtl/core/spectral_tone_command_decoder_macros.svh]
// assertion macros for the tone decoder rtl
// no dependencies; included by stcd_cmd, the only module that carries assertions
`ifndef SPECTRAL_TONE_COMMAND_DECODER_MACROS_SVH
`define SPECTRAL_TONE_COMMAND_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define STCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define STCD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define STCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/stcd_pkg.sv]
// shared types, codes and band decode function of the tone command decoder
// no dependencies
package stcd_pkg;

  localparam int BIN_BITS_DEF = 10;
  localparam int BIN_BITS_MAX = 12;
  localparam int MAG_W        = 32;
  localparam int WIN_W        = 10;
  localparam int REG_ADDR_W   = 4;
  localparam int OUT_DATA_W   = 8;

  localparam logic [MAG_W-1:0] THRESH_RESET   = 32'd100000;
  localparam logic [WIN_W-1:0] WIN_LOW_RESET  = 10'd26;
  localparam logic [WIN_W-1:0] WIN_HIGH_RESET = 10'd47;

  // register indexes
  localparam logic [1:0] REG_THRESH   = 2'd0;
  localparam logic [1:0] REG_WIN_LOW  = 2'd1;
  localparam logic [1:0] REG_WIN_HIGH = 2'd2;

  // request kinds
  localparam logic [1:0] REQ_BIN   = 2'd0;
  localparam logic [1:0] REQ_TAKE  = 2'd1;
  localparam logic [1:0] REQ_READY = 2'd2;
  localparam logic [1:0] REQ_NEXT  = 2'd3;

  // command codes
  localparam logic [1:0] CMD_END_GAME  = 2'd0;
  localparam logic [1:0] CMD_PONG_INIT = 2'd1;
  localparam logic [1:0] CMD_ALPHABET  = 2'd2;

  // letter codes
  localparam logic [2:0] LET_NONE  = 3'd0;
  localparam logic [2:0] LET_M     = 3'd1;
  localparam logic [2:0] LET_O     = 3'd2;
  localparam logic [2:0] LET_N     = 3'd3;
  localparam logic [2:0] LET_D     = 3'd4;
  localparam logic [2:0] LET_A     = 3'd5;
  localparam logic [2:0] LET_SIXTH = 3'd6;

  // band centers
  localparam logic [BIN_BITS_MAX-1:0] CTR_END   = 12'd43;
  localparam logic [BIN_BITS_MAX-1:0] CTR_PONG  = 12'd28;
  localparam logic [BIN_BITS_MAX-1:0] CTR_ALPHA = 12'd30;
  localparam logic [BIN_BITS_MAX-1:0] CTR_M     = 12'd32;
  localparam logic [BIN_BITS_MAX-1:0] CTR_O     = 12'd34;
  localparam logic [BIN_BITS_MAX-1:0] CTR_N     = 12'd36;
  localparam logic [BIN_BITS_MAX-1:0] CTR_D     = 12'd38;
  localparam logic [BIN_BITS_MAX-1:0] CTR_A     = 12'd41;
  localparam logic [BIN_BITS_MAX-1:0] CTR_SIXTH = 12'd45;

  typedef struct packed {
    logic [MAG_W-1:0] thresh;
    logic [WIN_W-1:0] win_lo;
    logic [WIN_W-1:0] win_hi;
  } cfg_t;

  typedef struct packed {
    logic                    confirm;
    logic [BIN_BITS_MAX-1:0] bin;
  } frame_evt_t;

  // first member sits in the top bits, so command_valid lands at bit 0
  typedef struct packed {
    logic       letter_is_ready;
    logic [2:0] letter_code;
    logic [1:0] command_code;
    logic       command_valid;
  } result_t;

  typedef struct packed {
    logic       fired;
    logic [1:0] cmd;
    logic       alpha;
    logic [2:0] letter;
  } dec_t;

  function automatic logic in_band(input logic [BIN_BITS_MAX-1:0] b,
                                   input logic [BIN_BITS_MAX-1:0] c);
    in_band = (b >= c - 12'd1) && (b <= c + 12'd1);
  endfunction

  // priority band decode of a confirmed bin
  function automatic dec_t band_decode(input logic [BIN_BITS_MAX-1:0] b,
                                       input logic alpha,
                                       input logic [2:0] pend);
    dec_t       d;
    logic [2:0] code;
    d.fired  = 1'b0;
    d.cmd    = CMD_END_GAME;
    d.alpha  = alpha;
    d.letter = pend;
    code     = LET_NONE;
    if (in_band(b, CTR_END)) begin
      d.fired = 1'b1;
      d.cmd   = CMD_END_GAME;
      d.alpha = 1'b0;
    end else if (in_band(b, CTR_PONG)) begin
      d.fired = 1'b1;
      d.cmd   = CMD_PONG_INIT;
    end else if (in_band(b, CTR_ALPHA)) begin
      d.fired  = 1'b1;
      d.cmd    = CMD_ALPHABET;
      d.alpha  = 1'b1;
      d.letter = LET_NONE;
    end else begin
      if (in_band(b, CTR_M))          code = LET_M;
      else if (in_band(b, CTR_O))     code = LET_O;
      else if (in_band(b, CTR_N))     code = LET_N;
      else if (in_band(b, CTR_D))     code = LET_D;
      else if (in_band(b, CTR_A))     code = LET_A;
      else if (in_band(b, CTR_SIXTH)) code = LET_SIXTH;
      if (code == LET_NONE) begin
        d.letter = LET_NONE;
      end else if (alpha && (pend == LET_NONE)) begin
        d.letter = code;
      end
    end
    band_decode = d;
  endfunction

endpackage

[rtl/core/stcd_cfg_regs.sv]
// apb-style configuration registers: threshold and bin window
// depends on stcd_pkg
module stcd_cfg_regs import stcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_THRESH:   cfg_nxt.thresh = pwdata;
        REG_WIN_LOW:  cfg_nxt.win_lo = pwdata[WIN_W-1:0];
        REG_WIN_HIGH: cfg_nxt.win_hi = pwdata[WIN_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESH:   prdata = cfg_r.thresh;
      REG_WIN_LOW:  prdata = 32'(cfg_r.win_lo);
      REG_WIN_HIGH: prdata = 32'(cfg_r.win_hi);
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh <= THRESH_RESET;
      cfg_r.win_lo <= WIN_LOW_RESET;
      cfg_r.win_hi <= WIN_HIGH_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/core/stcd_peak.sv]
// per-frame peak search and two-frame candidate confirmation
// depends on stcd_pkg
module stcd_peak import stcd_pkg::*; #(
  parameter int BIN_BITS = BIN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [MAG_W-1:0]    mag,
  input  logic [BIN_BITS-1:0] bin,
  input  logic                fend,
  input  cfg_t                cfg,
  output frame_evt_t          evt
);

  logic [MAG_W-1:0]    run_max_r,  run_max_nxt;
  logic [BIN_BITS-1:0] run_bin_r,  run_bin_nxt;
  logic                found_r,    found_nxt;
  logic                cand_vld_r, cand_vld_nxt;
  logic [BIN_BITS-1:0] cand_bin_r, cand_bin_nxt;

  logic [BIN_BITS-1:0] lo, hi;
  logic [MAG_W-1:0]    ref_mag;
  logic                hit, upd_found;
  logic [BIN_BITS-1:0] upd_bin;

  assign lo        = BIN_BITS'(cfg.win_lo);
  assign hi        = BIN_BITS'(cfg.win_hi);
  // before any peak this frame the live threshold is the bar
  assign ref_mag   = found_r ? run_max_r : cfg.thresh;
  assign hit       = (bin >= lo) && (bin <= hi) && (mag > ref_mag);
  assign upd_found = found_r || hit;
  assign upd_bin   = hit ? bin : run_bin_r;

  assign evt.confirm = fire && fend && cand_vld_r && upd_found && (upd_bin == cand_bin_r);
  assign evt.bin     = BIN_BITS_MAX'(cand_bin_r);

  always_comb begin
    run_max_nxt  = run_max_r;
    run_bin_nxt  = run_bin_r;
    found_nxt    = found_r;
    cand_vld_nxt = cand_vld_r;
    cand_bin_nxt = cand_bin_r;
    if (fire) begin
      if (hit) begin
        run_max_nxt = mag;
        run_bin_nxt = bin;
      end
      if (fend) begin
        found_nxt = 1'b0;
        if (!cand_vld_r) begin
          if (upd_found) begin
            cand_vld_nxt = 1'b1;
            cand_bin_nxt = upd_bin;
          end
        end else begin
          // confirmed or not, the candidate is used up
          cand_vld_nxt = 1'b0;
        end
      end else begin
        found_nxt = upd_found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      cand_vld_r <= 1'b0;
      cand_bin_r <= '0;
    end else begin
      found_r    <= found_nxt;
      cand_vld_r <= cand_vld_nxt;
      cand_bin_r <= cand_bin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_max_r <= run_max_nxt;
    run_bin_r <= run_bin_nxt;
  end

endmodule

[rtl/core/stcd_cmd.sv]
// command and letter state, query handling and result register
// depends on stcd_pkg and the assertion macros header
`include "spectral_tone_command_decoder_macros.svh"
module stcd_cmd import stcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [1:0] req,
  input  frame_evt_t evt,
  input  logic       res_ready,
  output logic       res_valid,
  output result_t    res
);

  logic       alpha_r, alpha_nxt;
  logic [2:0] pend_r,  pend_nxt;
  logic       vld_r,   vld_nxt;
  result_t    res_r,   res_nxt;
  dec_t       dec;
  logic       emit;

  assign dec       = band_decode(evt.bin, alpha_r, pend_r);
  assign res_valid = vld_r;
  assign res       = res_r;

  always_comb begin
    alpha_nxt = alpha_r;
    pend_nxt  = pend_r;
    emit      = 1'b0;
    res_nxt   = '0;
    if (fire) begin
      case (req)
        REQ_BIN: begin
          if (evt.confirm) begin
            alpha_nxt             = dec.alpha;
            pend_nxt              = dec.letter;
            emit                  = 1'b1;
            res_nxt.command_valid = dec.fired;
            res_nxt.command_code  = dec.fired ? dec.cmd : CMD_END_GAME;
            res_nxt.letter_code   = dec.letter;
          end
        end
        REQ_TAKE: begin
          pend_nxt            = LET_NONE;
          emit                = 1'b1;
          res_nxt.letter_code = pend_r;
        end
        REQ_READY: begin
          emit                    = 1'b1;
          res_nxt.letter_code     = pend_r;
          res_nxt.letter_is_ready = (pend_r != LET_NONE);
          if (pend_r != LET_NONE) alpha_nxt = 1'b0;
        end
        REQ_NEXT: begin
          alpha_nxt = 1'b1;
          pend_nxt  = LET_NONE;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
    vld_nxt = emit ? 1'b1 : (res_ready ? 1'b0 : vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 1'b0;
      pend_r  <= LET_NONE;
      vld_r   <= 1'b0;
    end else begin
      alpha_r <= alpha_nxt;
      pend_r  <= pend_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res_r <= res_nxt;
  end

  `STCD_ASSERT_IMPL(a_ready_no_cmd, clk, rst_n, vld_r && res_r.letter_is_ready, !res_r.command_valid)
  `STCD_ASSERT_IMPL(a_code_needs_cmd, clk, rst_n, vld_r && (res_r.command_code != CMD_END_GAME), res_r.command_valid)
  `STCD_ASSERT_NEXT(a_take_clears, clk, rst_n, fire && (req == REQ_TAKE), pend_r == LET_NONE)
  `STCD_ASSERT_NEXT(a_next_arms, clk, rst_n, fire && (req == REQ_NEXT), alpha_r && (pend_r == LET_NONE))

endmodule

[rtl/core/spectral_tone_command_decoder.sv]
// top level of the spectral tone command decoder: input register, stream and apb ports
// depends on stcd_pkg, stcd_cfg_regs, stcd_peak and stcd_cmd
// Takes one transaction per clock unless the result side stalls: a magnitude bin
// (tuser 0) or a letter query (tuser 1 take, 2 ready, 3 next). Each transaction is
// held in the input register, where a single compare against the running peak plus
// the band decode resolves it, and its result is then loaded into the output register;
// the block sustains one transaction per cycle while the result side keeps taking.
// A stalled result holds in the output register while one further transaction waits
// in the input register. Only a confirmed frame end and the take and ready queries
// produce results. Configuration is to be written only while the stream is idle;
// the block itself does not enforce this. No memory and no clearing pass after reset.
module spectral_tone_command_decoder import stcd_pkg::*; #(
  parameter int BIN_BITS = BIN_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // magnitude [31:0], bin_index above it, zero padding to whole bytes
  input  logic [((MAG_W + BIN_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // req_type [1:0]
  input  logic [1:0]                             in_tuser,
  input  logic                                   in_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // command_valid [0], command_code [2:1], letter_code [5:3], letter_is_ready [6], zero [7]
  output logic [OUT_DATA_W-1:0]                  out_tdata,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [REG_ADDR_W-1:0]                  cfg_paddr,
  input  logic [31:0]                            cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);

  cfg_t                cfg;
  frame_evt_t          evt;
  result_t             res;

  logic                s1_vld_r, s1_vld_nxt;
  logic [1:0]          s1_req_r;
  logic [MAG_W-1:0]    s1_mag_r;
  logic [BIN_BITS-1:0] s1_bin_r;
  logic                s1_fend_r;
  logic                advance, fire, take_in;

  // the result register is free or being emptied this cycle
  assign advance   = !out_tvalid || out_tready;
  assign fire      = s1_vld_r && advance;
  assign in_tready = !s1_vld_r || advance;
  assign take_in   = in_tvalid && in_tready;
  assign s1_vld_nxt = take_in ? 1'b1 : (fire ? 1'b0 : s1_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_req_r  <= in_tuser;
      s1_mag_r  <= in_tdata[MAG_W-1:0];
      s1_bin_r  <= in_tdata[MAG_W +: BIN_BITS];
      s1_fend_r <= in_tlast;
    end
  end

  stcd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  stcd_peak #(
    .BIN_BITS (BIN_BITS)
  ) u_peak (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire && (s1_req_r == REQ_BIN)),
    .mag   (s1_mag_r),
    .bin   (s1_bin_r),
    .fend  (s1_fend_r),
    .cfg   (cfg),
    .evt   (evt)
  );

  stcd_cmd u_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .req       (s1_req_r),
    .evt       (evt),
    .res_ready (out_tready),
    .res_valid (out_tvalid),
    .res       (res)
  );

  assign out_tdata = {1'b0, res};

endmodule
